/* rtl/core/slot_allocator_bump_free_stack_defines.svh */
// Assertion macros shared by the slot allocator RTL.
// Included by modules that carry concurrent assertions; no other dependencies.
`ifndef SLOT_ALLOCATOR_BUMP_FREE_STACK_DEFINES_SVH
`define SLOT_ALLOCATOR_BUMP_FREE_STACK_DEFINES_SVH

// expression must hold at every clock edge out of reset
`define SABFS_ASSERT_HOLDS(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// consequent must hold in the same cycle as the antecedent
`define SABFS_ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

/* rtl/core/sabfs_pkg.sv */
// Types and constants for the slot allocator (bump pointer plus free stack).
// No dependencies; imported by every module of the block except sabfs_ram.
`timescale 1ns / 1ps

package sabfs_pkg;

    localparam int MAX_SLOTS   = 1024;
    localparam int FREE_DEPTH  = 1024;
    localparam int QUEUE_DEPTH = 2;

    localparam int IDX_W     = 10;
    localparam int CAP_W     = 11;
    localparam int SUM_W     = CAP_W + 1;
    localparam int STACK_AW  = $clog2(FREE_DEPTH);
    localparam int STACK_CW  = $clog2(FREE_DEPTH + 1);
    localparam int S_TDATA_W = 24;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 16;
    localparam int M_TUSER_W = 3;
    localparam int PADDR_W   = 3;

    localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(1024);
    localparam logic [CAP_W-1:0] CAP_LIMIT = CAP_W'(MAX_SLOTS);

    typedef enum logic [0:0] {
        REG_HEAP_CAPACITY = 1'b0
    } t_reg;

    typedef enum logic [1:0] {
        ACT_ALLOC_ONE = 2'd0,
        ACT_ALLOC_RUN = 2'd1,
        ACT_FREE_ONE  = 2'd2,
        ACT_FREE_RUN  = 2'd3
    } t_action;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_FULL     = 3'd1,
        ST_EMPTY    = 3'd2,
        ST_RANGE    = 3'd3,
        ST_OVERFLOW = 3'd4
    } t_status;

    typedef enum logic [2:0] {
        K_ALLOC_ONE,
        K_ALLOC_RUN,
        K_PUSH,
        K_EMPTY,
        K_RANGE
    } t_kind;

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_PUSH,
        S_HOLD
    } t_state;

    typedef struct packed {
        t_kind              kind;
        logic [IDX_W-1:0]   start;
        logic [CAP_W-1:0]   count;
    } t_cmd;

    typedef struct packed {
        logic [1:0]         pad;
        logic [CAP_W-1:0]   slot_count;
        logic               handle_valid;
        logic [IDX_W-1:0]   slot_index;
    } t_s_data;

    typedef struct packed {
        logic [M_TDATA_W-IDX_W-1:0] pad;
        logic [IDX_W-1:0]           granted_index;
    } t_m_data;

endpackage

/* rtl/core/sabfs_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module sabfs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/core/sabfs_front.sv */
// Front end: takes input items and classifies them into back-end commands.
// Depends on sabfs_pkg.
`timescale 1ns / 1ps

module sabfs_front
    import sabfs_pkg::*;
(
    input  logic                 i_s_tvalid,
    output logic                 o_s_tready,
    input  logic [S_TDATA_W-1:0] i_s_tdata,
    input  logic [S_TUSER_W-1:0] i_s_tuser,
    input  logic [CAP_W-1:0]     i_cap,
    input  logic                 i_full,
    output logic                 o_push,
    output t_cmd                 o_cmd
);

    t_s_data          data;
    t_action          action;
    logic [CAP_W-1:0] push_count;
    logic [SUM_W-1:0] run_end;
    logic             out_of_range;

    always_comb begin
        data         = t_s_data'(i_s_tdata);
        action       = t_action'(i_s_tuser);
        push_count   = (action == ACT_FREE_ONE) ? CAP_W'(1) : data.slot_count;
        run_end      = SUM_W'(data.slot_index) + SUM_W'(push_count);
        out_of_range = run_end > SUM_W'(i_cap);

        o_cmd.start = data.slot_index;
        o_cmd.count = push_count;
        case (action)
            ACT_ALLOC_ONE: begin
                o_cmd.kind = K_ALLOC_ONE;
            end
            ACT_ALLOC_RUN: begin
                o_cmd.kind = (data.slot_count == '0) ? K_EMPTY : K_ALLOC_RUN;
            end
            ACT_FREE_ONE, ACT_FREE_RUN: begin
                if (!data.handle_valid || push_count == '0) begin
                    o_cmd.kind = K_EMPTY;
                end else if (out_of_range) begin
                    o_cmd.kind = K_RANGE;
                end else begin
                    o_cmd.kind = K_PUSH;
                end
            end
            default: begin
                o_cmd.kind = K_EMPTY;
            end
        endcase
    end

    assign o_s_tready = !i_full;
    assign o_push     = i_s_tvalid && !i_full;

endmodule

/* rtl/core/sabfs_queue.sv */
// Short command queue between the front end and the back end.
// Depends on sabfs_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "slot_allocator_bump_free_stack_defines.svh"

module sabfs_queue
    import sabfs_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    output logic o_full,
    output logic o_valid,
    output t_cmd o_cmd,
    input  logic i_pop
);

    localparam int QA_W = $clog2(QUEUE_DEPTH);
    localparam int QF_W = $clog2(QUEUE_DEPTH + 1);

    t_cmd            r_mem [QUEUE_DEPTH];
    logic [QA_W-1:0] r_wr;
    logic [QA_W-1:0] r_rd;
    logic [QF_W-1:0] r_fill;
    logic [QA_W-1:0] n_wr;
    logic [QA_W-1:0] n_rd;
    logic [QF_W-1:0] n_fill;

    always_comb begin
        n_wr   = r_wr;
        n_rd   = r_rd;
        n_fill = r_fill;
        if (i_push) begin
            n_wr = (r_wr == QA_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr + QA_W'(1);
        end
        if (i_pop) begin
            n_rd = (r_rd == QA_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd + QA_W'(1);
        end
        if (i_push && !i_pop) begin
            n_fill = r_fill + QF_W'(1);
        end else if (!i_push && i_pop) begin
            n_fill = r_fill - QF_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr   <= '0;
            r_rd   <= '0;
            r_fill <= '0;
        end else begin
            r_wr   <= n_wr;
            r_rd   <= n_rd;
            r_fill <= n_fill;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

    assign o_full  = (r_fill == QF_W'(QUEUE_DEPTH));
    assign o_valid = (r_fill != '0);
    assign o_cmd   = r_mem[r_rd];

    `SABFS_ASSERT_IMPLIES(a_no_push_full, i_clk, i_rst_n, i_push, !o_full, "push into full queue")
    `SABFS_ASSERT_IMPLIES(a_no_pop_empty, i_clk, i_rst_n, i_pop, o_valid, "pop from empty queue")
    `SABFS_ASSERT_HOLDS(a_fill_bound, i_clk, i_rst_n, r_fill <= QF_W'(QUEUE_DEPTH), "queue overfilled")

endmodule

/* rtl/core/sabfs_back.sv */
// Back end: bump pointer, free stack control and the result register.
// Depends on sabfs_pkg, sabfs_ram and the assertion macro header.
`timescale 1ns / 1ps
`include "slot_allocator_bump_free_stack_defines.svh"

module sabfs_back
    import sabfs_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic [CAP_W-1:0]     i_cap,
    input  logic                 i_q_valid,
    input  t_cmd                 i_q_cmd,
    output logic                 o_q_pop,
    output logic                 o_m_tvalid,
    input  logic                 i_m_tready,
    output logic [M_TDATA_W-1:0] o_m_tdata,
    output logic [M_TUSER_W-1:0] o_m_tuser
);

    t_state              r_state;
    t_state              n_state;
    logic [CAP_W-1:0]    r_nfs;
    logic [CAP_W-1:0]    n_nfs;
    logic [STACK_CW-1:0] r_cnt;
    logic [STACK_CW-1:0] n_cnt;
    logic [IDX_W-1:0]    r_ptr;
    logic [IDX_W-1:0]    n_ptr;
    logic [CAP_W-1:0]    r_left;
    logic [CAP_W-1:0]    n_left;
    logic [IDX_W-1:0]    r_res_granted;
    t_status             r_res_status;
    logic                r_out_valid;
    logic [IDX_W-1:0]    r_out_granted;
    t_status             r_out_status;

    logic                out_free;
    logic                res_fire;
    logic [IDX_W-1:0]    res_granted;
    t_status             res_status;
    logic                go_read;
    logic                go_push;
    logic                ram_we;
    logic                ram_re;
    logic [STACK_AW-1:0] ram_waddr;
    logic [STACK_AW-1:0] ram_raddr;
    logic [IDX_W-1:0]    ram_rdata;
    logic [STACK_CW-1:0] cnt_dec;
    logic [SUM_W-1:0]    run_end;
    logic [SUM_W-1:0]    room;
    logic                overflow;
    t_m_data             m_data;

    assign out_free  = !r_out_valid || i_m_tready;
    assign cnt_dec   = r_cnt - STACK_CW'(1);
    assign ram_raddr = cnt_dec[STACK_AW-1:0];
    assign ram_waddr = r_cnt[STACK_AW-1:0];
    assign run_end   = SUM_W'(r_nfs) + SUM_W'(i_q_cmd.count);
    assign room      = SUM_W'(FREE_DEPTH) - SUM_W'(r_cnt);
    assign overflow  = SUM_W'(i_q_cmd.count) > room;

    // datapath and handshake outputs
    always_comb begin
        o_q_pop     = 1'b0;
        ram_we      = 1'b0;
        ram_re      = 1'b0;
        go_read     = 1'b0;
        go_push     = 1'b0;
        res_fire    = 1'b0;
        res_granted = '0;
        res_status  = ST_OK;
        n_nfs       = r_nfs;
        n_cnt       = r_cnt;
        n_ptr       = r_ptr;
        n_left      = r_left;
        case (r_state)
            S_IDLE: begin
                if (i_q_valid) begin
                    o_q_pop = 1'b1;
                    case (i_q_cmd.kind)
                        K_ALLOC_ONE: begin
                            if (r_cnt != '0) begin
                                ram_re  = 1'b1;
                                go_read = 1'b1;
                                n_cnt   = cnt_dec;
                            end else if (r_nfs < i_cap) begin
                                res_fire    = 1'b1;
                                res_granted = r_nfs[IDX_W-1:0];
                                n_nfs       = r_nfs + CAP_W'(1);
                            end else begin
                                res_fire   = 1'b1;
                                res_status = ST_FULL;
                            end
                        end
                        K_ALLOC_RUN: begin
                            res_fire = 1'b1;
                            if (run_end > SUM_W'(i_cap)) begin
                                res_status = ST_FULL;
                            end else begin
                                res_granted = r_nfs[IDX_W-1:0];
                                n_nfs       = run_end[CAP_W-1:0];
                            end
                        end
                        K_PUSH: begin
                            if (overflow) begin
                                res_fire   = 1'b1;
                                res_status = ST_OVERFLOW;
                            end else begin
                                go_push = 1'b1;
                                n_ptr   = i_q_cmd.start;
                                n_left  = i_q_cmd.count;
                            end
                        end
                        K_RANGE: begin
                            res_fire   = 1'b1;
                            res_status = ST_RANGE;
                        end
                        default: begin
                            res_fire   = 1'b1;
                            res_status = ST_EMPTY;
                        end
                    endcase
                end
            end
            S_READ: begin
                res_fire    = 1'b1;
                res_granted = ram_rdata;
            end
            S_PUSH: begin
                ram_we = 1'b1;
                n_cnt  = r_cnt + STACK_CW'(1);
                n_ptr  = r_ptr + IDX_W'(1);
                n_left = r_left - CAP_W'(1);
                if (r_left == CAP_W'(1)) begin
                    res_fire = 1'b1;
                end
            end
            S_HOLD: begin
                res_fire    = 1'b1;
                res_granted = r_res_granted;
                res_status  = r_res_status;
            end
            default: begin
                res_fire = 1'b0;
            end
        endcase
    end

    // next state
    always_comb begin
        n_state = r_state;
        if (res_fire) begin
            n_state = out_free ? S_IDLE : S_HOLD;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (go_read) begin
                        n_state = S_READ;
                    end else if (go_push) begin
                        n_state = S_PUSH;
                    end
                end
                default: begin
                    n_state = r_state;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_nfs       <= '0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_nfs   <= n_nfs;
            r_cnt   <= n_cnt;
            if (res_fire && out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_ptr  <= n_ptr;
        r_left <= n_left;
        if (res_fire && out_free) begin
            r_out_granted <= res_granted;
            r_out_status  <= res_status;
        end
        if (res_fire && !out_free) begin
            r_res_granted <= res_granted;
            r_res_status  <= res_status;
        end
    end

    sabfs_ram #(
        .WIDTH (IDX_W),
        .DEPTH (FREE_DEPTH)
    ) u_stack (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (r_ptr),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        m_data               = '0;
        m_data.granted_index = r_out_granted;
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = m_data;
    assign o_m_tuser  = r_out_status;

    `SABFS_ASSERT_HOLDS(a_stack_bound, i_clk, i_rst_n, r_cnt <= STACK_CW'(FREE_DEPTH), "free stack count past depth")
    `SABFS_ASSERT_HOLDS(a_bump_bound, i_clk, i_rst_n, r_nfs <= CAP_LIMIT, "bump pointer past heap limit")
    `SABFS_ASSERT_IMPLIES(a_read_after_pop, i_clk, i_rst_n, r_state == S_READ, $past(o_q_pop) && $past(ram_re), "stack read without pop")

endmodule

/* rtl/core/slot_allocator_bump_free_stack.sv */
// Top level of the slot allocator: APB register, front end, queue, back end.
// Depends on sabfs_pkg, sabfs_front, sabfs_queue and sabfs_back.
//
//   channel   dir  handshake                      payload
//   s_*       in   s_tvalid / s_tready            tdata slot fields, tuser action
//   m_*       out  m_tvalid / m_tready            tdata granted_index, tuser status
//   APB       in   psel, penable, pwrite, pready  heap_capacity at byte address 0
//
// Front end classifies an item in the cycle it is taken and queues it (two entries).
// Back end: most items finish in idle; an allocate-one from the free stack passes
// a read state (registered stack RAM read); a free of count slots is set up in idle, then
// pushes one slot a cycle. Reset clears bump pointer and stack count; no clearing pass.
// A stalled result holds in the output register; the queue takes items until full.
`timescale 1ns / 1ps

module slot_allocator_bump_free_stack
    import sabfs_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // slot_index, handle_valid, slot_count
    input  logic [S_TUSER_W-1:0] s_tuser,   // action
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,   // granted_index
    output logic [M_TUSER_W-1:0] m_tuser,   // status
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [PADDR_W-1:0]   paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready
);

    logic [CAP_W-1:0] r_cap;
    logic [CAP_W-1:0] cap_eff;
    t_reg             reg_sel;
    logic             q_push;
    logic             q_full;
    logic             q_valid;
    logic             q_pop;
    t_cmd             front_cmd;
    t_cmd             q_cmd;

    assign pready  = 1'b1;
    assign reg_sel = t_reg'(paddr[PADDR_W-1]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap <= CAP_RESET;
        end else if (psel && penable && pwrite && reg_sel == REG_HEAP_CAPACITY) begin
            r_cap <= pwdata[CAP_W-1:0];
        end
    end

    always_comb begin
        case (reg_sel)
            REG_HEAP_CAPACITY: prdata = 32'(r_cap);
            default:           prdata = '0;
        endcase
    end

    assign cap_eff = (r_cap > CAP_LIMIT) ? CAP_LIMIT : r_cap;

    sabfs_front u_front (
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tuser  (s_tuser),
        .i_cap      (cap_eff),
        .i_full     (q_full),
        .o_push     (q_push),
        .o_cmd      (front_cmd)
    );

    sabfs_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (front_cmd),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_cmd   (q_cmd),
        .i_pop   (q_pop)
    );

    sabfs_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cap      (cap_eff),
        .i_q_valid  (q_valid),
        .i_q_cmd    (q_cmd),
        .o_q_pop    (q_pop),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata),
        .o_m_tuser  (m_tuser)
    );

endmodule

/* tb/sv/tb_top.sv */
// Self-checking bench for slot_allocator_bump_free_stack: drives allocate and free items,
// predicts each granted index and status, and compares them with the result stream.
// Depends on sabfs_pkg and the block's RTL.
`timescale 1ns / 1ps

module tb_top;
    import sabfs_pkg::*;

    localparam int unsigned CYCLE_LIMIT   = 600000;
    localparam int unsigned CONFIG_SETTLE = 1040;
    localparam int unsigned END_SETTLE    = 64;

    typedef struct packed {
        logic [IDX_W-1:0] granted_index;
        t_status          status;
    } t_grant;

    logic                 i_clk;
    logic                 i_rst_n  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;   // slot_index, handle_valid, slot_count
    logic [S_TUSER_W-1:0] s_tuser  = '0;   // action
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;         // granted_index
    logic [M_TUSER_W-1:0] m_tuser;         // status
    logic                 psel     = 1'b0;
    logic                 penable  = 1'b0;
    logic                 pwrite   = 1'b0;
    logic [PADDR_W-1:0]   paddr    = '0;
    logic [31:0]          pwdata   = '0;
    logic [31:0]          prdata;
    logic                 pready;

    // predicted allocator state
    logic [CAP_W-1:0]     cap_reg  = CAP_RESET;
    int                   fresh_ptr = 0;
    int                   stk_cnt   = 0;
    logic [IDX_W-1:0]     free_slots [FREE_DEPTH];

    t_grant               grants_due [$];
    t_grant               head;
    int                   errors      = 0;
    int unsigned          cycle_count = 0;
    int unsigned          tx_idle_pct = 0;
    int unsigned          rx_stall_pct = 0;
    int unsigned          rx_hold_len = 0;

    slot_allocator_bump_free_stack i_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always begin
        i_clk = 1'b0;
        #10;
        i_clk = 1'b1;
        #10;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // receiver: random stalls, or a long hold-off when requested
    always @(posedge i_clk) begin
        if (rx_hold_len > 0) begin
            rx_hold_len = rx_hold_len - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= rx_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_tvalid && m_tready) begin
            if (grants_due.size() == 0) begin
                $error("unexpected item: granted_index %0d, status %0d",
                       m_tdata[IDX_W-1:0], m_tuser);
                errors++;
            end else begin
                head = grants_due.pop_front();
                if (m_tdata[IDX_W-1:0] !== head.granted_index) begin
                    $error("granted_index: expected %0d, actual %0d",
                           head.granted_index, m_tdata[IDX_W-1:0]);
                    errors++;
                end
                if (m_tuser !== head.status) begin
                    $error("status: expected %0d, actual %0d", head.status, m_tuser);
                    errors++;
                end
            end
        end
    end

    function automatic int cap_in_use();
        return (int'(cap_reg) > MAX_SLOTS) ? MAX_SLOTS : int'(cap_reg);
    endfunction

    function automatic t_grant predict_grant(t_action act, logic [IDX_W-1:0] idx, logic vld,
                                             logic [CAP_W-1:0] cnt);
        t_grant g;
        int     lim;
        int     span;
        lim  = cap_in_use();
        span = (act == ACT_FREE_ONE) ? 1 : int'(cnt);
        g.granted_index = '0;
        g.status        = ST_OK;
        case (act)
            ACT_ALLOC_ONE: begin
                if (stk_cnt > 0) begin
                    stk_cnt--;
                    g.granted_index = free_slots[stk_cnt];
                end else if (fresh_ptr < lim) begin
                    g.granted_index = IDX_W'(fresh_ptr);
                    fresh_ptr++;
                end else begin
                    g.status = ST_FULL;
                end
            end
            ACT_ALLOC_RUN: begin
                if (span == 0) begin
                    g.status = ST_EMPTY;
                end else if (fresh_ptr + span > lim) begin
                    g.status = ST_FULL;
                end else begin
                    g.granted_index = IDX_W'(fresh_ptr);
                    fresh_ptr += span;
                end
            end
            default: begin
                if (!vld || span == 0) begin
                    g.status = ST_EMPTY;
                end else if (int'(idx) + span > lim) begin
                    g.status = ST_RANGE;
                end else if (span > FREE_DEPTH - stk_cnt) begin
                    g.status = ST_OVERFLOW;
                end else begin
                    for (int k = 0; k < span; k++) begin
                        free_slots[stk_cnt] = IDX_W'(int'(idx) + k);
                        stk_cnt++;
                    end
                end
            end
        endcase
        return g;
    endfunction

    task automatic send_item(t_action act, logic [IDX_W-1:0] idx, logic vld,
                             logic [CAP_W-1:0] cnt);
        t_s_data d;
        t_grant  due;
        d.pad          = '0;
        d.slot_count   = cnt;
        d.handle_valid = vld;
        d.slot_index   = idx;
        while (tx_idle_pct > 0 && $urandom_range(99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= d;
        s_tuser  <= act;
        do @(posedge i_clk); while (!s_tready);
        due        = predict_grant(act, idx, vld, cnt);
        grants_due = {grants_due, due};
    endtask

    task automatic quiesce(int unsigned settle);
        s_tvalid <= 1'b0;
        while (grants_due.size() != 0) @(posedge i_clk);
        repeat (settle) @(posedge i_clk);
    endtask

    task automatic write_register(t_reg r, logic [31:0] value);
        quiesce(CONFIG_SETTLE);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= PADDR_W'(4 * int'(r));
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (r == REG_HEAP_CAPACITY)
            cap_reg = value[CAP_W-1:0];
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic test_directed_ops();
        send_item(ACT_ALLOC_RUN, '0, 1'b0, 11'd0);       // empty run request
        send_item(ACT_ALLOC_ONE, '0, 1'b0, '0);
        send_item(ACT_ALLOC_RUN, '0, 1'b0, 11'd3);
        send_item(ACT_FREE_ONE, 10'd1023, 1'b0, '0);      // invalid handle
        send_item(ACT_FREE_RUN, 10'd0, 1'b1, 11'd0);      // zero-count free
        send_item(ACT_FREE_RUN, 10'd0, 1'b0, 11'd5);
        send_item(ACT_FREE_ONE, 10'd2, 1'b1, '0);
        send_item(ACT_FREE_ONE, 10'd2, 1'b1, '0);         // double free
        send_item(ACT_ALLOC_ONE, '0, 1'b0, '0);
        send_item(ACT_ALLOC_ONE, '0, 1'b0, '0);
        send_item(ACT_ALLOC_ONE, '0, 1'b0, '0);
        send_item(ACT_FREE_RUN, 10'd1, 1'b1, 11'd1024);   // past largest index
        send_item(ACT_FREE_RUN, 10'd1023, 1'b1, 11'd2);
        send_item(ACT_FREE_RUN, 10'd0, 1'b1, 11'd2047);
        send_item(ACT_FREE_RUN, 10'd1023, 1'b1, 11'd1);
        send_item(ACT_FREE_RUN, 10'd0, 1'b1, 11'd1024);   // no room for whole run
        send_item(ACT_ALLOC_RUN, '0, 1'b0, 11'd1024);     // run too large
        send_item(ACT_ALLOC_RUN, 10'd1023, 1'b1, 11'd2047);
        send_item(ACT_ALLOC_ONE, '0, 1'b0, '0);
        send_item(ACT_FREE_RUN, 10'd10, 1'b1, 11'd4);
    endtask

    task automatic test_capacity_limits();
        tx_idle_pct  = 30;
        rx_stall_pct = 30;
        write_register(REG_HEAP_CAPACITY, 32'd8);
        while (stk_cnt > 0)
            send_item(ACT_ALLOC_ONE, '0, 1'b0, '0);
        if (fresh_ptr < 8)
            send_item(ACT_ALLOC_RUN, '0, 1'b0, CAP_W'(8 - fresh_ptr));
        send_item(ACT_ALLOC_ONE, '0, 1'b0, '0);           // heap full
        send_item(ACT_ALLOC_RUN, '0, 1'b0, 11'd1);
        send_item(ACT_FREE_ONE, 10'd7, 1'b1, '0);
        send_item(ACT_FREE_ONE, 10'd8, 1'b1, '0);
        send_item(ACT_ALLOC_ONE, '0, 1'b0, '0);
        // capacity below the bump pointer: popping still works
        write_register(REG_HEAP_CAPACITY, 32'd1);
        send_item(ACT_FREE_ONE, 10'd0, 1'b1, '0);
        send_item(ACT_ALLOC_ONE, '0, 1'b0, '0);
        send_item(ACT_ALLOC_ONE, '0, 1'b0, '0);
        send_item(ACT_FREE_ONE, 10'd1, 1'b1, '0);
        write_register(REG_HEAP_CAPACITY, 32'd0);
        send_item(ACT_ALLOC_RUN, '0, 1'b0, 11'd1);
        send_item(ACT_ALLOC_ONE, '0, 1'b0, '0);
        send_item(ACT_FREE_ONE, 10'd0, 1'b1, '0);
        send_item(ACT_FREE_RUN, 10'd0, 1'b1, 11'd1);
        // above the slot count acts as the slot count
        write_register(REG_HEAP_CAPACITY, 32'd2047);
        send_item(ACT_FREE_ONE, 10'd1023, 1'b1, '0);
        send_item(ACT_FREE_RUN, 10'd1023, 1'b1, 11'd2);
        send_item(ACT_ALLOC_ONE, '0, 1'b0, '0);
    endtask

    task automatic test_random_traffic(int unsigned n_items);
        int unsigned      pick;
        int               lim;
        t_action          act;
        logic [IDX_W-1:0] idx;
        logic             vld;
        logic [CAP_W-1:0] cnt;
        repeat (n_items) begin
            pick = $urandom_range(99);
            lim  = cap_in_use();
            vld  = ($urandom_range(99) < 92);
            idx  = IDX_W'($urandom);
            case ($urandom_range(19))
                0:       cnt = CAP_W'($urandom);
                1:       cnt = '0;
                default: cnt = CAP_W'($urandom_range(1, 8));
            endcase
            if (pick < 40)
                act = ACT_ALLOC_ONE;
            else if (pick < 55)
                act = ACT_ALLOC_RUN;
            else if (pick < 88)
                act = ACT_FREE_ONE;
            else
                act = ACT_FREE_RUN;
            // mostly handles inside the heap
            if (lim > 0 && $urandom_range(99) < 85) begin
                if (act == ACT_FREE_RUN && int'(cnt) <= lim)
                    idx = IDX_W'($urandom_range(0, lim - int'(cnt)));
                else
                    idx = IDX_W'($urandom_range(0, lim - 1));
            end
            send_item(act, idx, vld, cnt);
        end
    endtask

    task automatic test_random_phases();
        int unsigned caps [6] = '{1024, 40, 300, 1, 2047, 700};
        for (int p = 0; p < 6; p++) begin
            write_register(REG_HEAP_CAPACITY, caps[p]);
            case (p % 4)
                0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
                1: begin tx_idle_pct = 61; rx_stall_pct = 0;  end
                2: begin tx_idle_pct = 0;  rx_stall_pct = 61; end
                default: begin tx_idle_pct = 30; rx_stall_pct = 30; end
            endcase
            test_random_traffic(250);
        end
    endtask

    task automatic test_output_backpressure();
        write_register(REG_HEAP_CAPACITY, 32'd512);
        tx_idle_pct  = 0;
        rx_stall_pct = 0;
        rx_hold_len  = 300;
        test_random_traffic(30);
    endtask

    task automatic test_full_free_stack();
        tx_idle_pct  = 0;
        rx_stall_pct = 30;
        write_register(REG_HEAP_CAPACITY, 32'd1024);
        if (stk_cnt < FREE_DEPTH)
            send_item(ACT_FREE_RUN, 10'd0, 1'b1, CAP_W'(FREE_DEPTH - stk_cnt));
        send_item(ACT_FREE_ONE, 10'd3, 1'b1, '0);         // stack full
        send_item(ACT_FREE_RUN, 10'd0, 1'b1, 11'd1);
        send_item(ACT_ALLOC_ONE, '0, 1'b0, '0);
        send_item(ACT_FREE_ONE, 10'd1022, 1'b1, '0);
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed_ops();
        test_capacity_limits();
        test_random_phases();
        test_output_backpressure();
        test_full_free_stack();
        quiesce(END_SETTLE);
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
